FILE: design/cgf_pkg.sv
// shared types and constants for the capture gating controller
`timescale 1ns / 1ps
`default_nettype none
package cgf_pkg;

    localparam int CMD_W      = 3;
    localparam int VALUE_W    = 2;
    localparam int PHASE_W    = 3;
    localparam int COOL_W     = 16;
    localparam int RETRY_W    = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_READINESS = 3'd0,
        CMD_SOURCE    = 3'd1,
        CMD_VIEW      = 3'd2,
        CMD_PERMIT    = 3'd3,
        CMD_FRAME     = 3'd4,
        CMD_TICK      = 3'd5
    } cmd_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE  = 3'd0,
        PH_REQ   = 3'd1,
        PH_CAP   = 3'd2,
        PH_COOL  = 3'd3,
        PH_FINAL = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        RDY_NOT   = 2'd0,
        RDY_READY = 2'd1,
        RDY_FINAL = 2'd2
    } rdy_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_COND  = 2'd1,
        EV_FRAME = 2'd2,
        EV_TICK  = 2'd3
    } ev_kind_t;

    typedef enum logic [1:0] {
        CD_READY  = 2'd0,
        CD_SOURCE = 2'd1,
        CD_VIEW   = 2'd2,
        CD_PERMIT = 2'd3
    } cond_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COOLDOWN = 1'd0,
        REG_RETRY    = 1'd1
    } cfg_reg_t;

    typedef struct packed {
        ev_kind_t kind;
        cond_t    cond;
        rdy_t     rdy;
        logic     flag;
    } event_t;

    typedef struct packed {
        logic   valid;
        event_t ev;
    } q_entry_t;

endpackage
`default_nettype wire

FILE: design/cgf_front.sv
// front end: accepts requests and classifies them into events
`timescale 1ns / 1ps
`default_nettype none
module cgf_front (
    input  wire logic [cgf_pkg::CMD_W-1:0]   cmd,
    input  wire logic [cgf_pkg::VALUE_W-1:0] value,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        q_full,
    output logic                             q_push,
    output cgf_pkg::event_t                  q_ev
);
    import cgf_pkg::*;

    rdy_t rdy_sat;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;
    assign rdy_sat  = (value == 2'd3) ? RDY_FINAL : rdy_t'(value);

    always_comb
    begin
        q_ev.kind = EV_NONE;
        q_ev.cond = CD_READY;
        q_ev.rdy  = rdy_sat;
        q_ev.flag = |value;
        unique case (cmd_t'(cmd))
            CMD_READINESS:
            begin
                q_ev.kind = EV_COND;
                q_ev.cond = CD_READY;
            end
            CMD_SOURCE:
            begin
                q_ev.kind = EV_COND;
                q_ev.cond = CD_SOURCE;
            end
            CMD_VIEW:
            begin
                q_ev.kind = EV_COND;
                q_ev.cond = CD_VIEW;
            end
            CMD_PERMIT:
            begin
                q_ev.kind = EV_COND;
                q_ev.cond = CD_PERMIT;
            end
            CMD_FRAME:
            begin
                q_ev.kind = EV_FRAME;
            end
            CMD_TICK:
            begin
                q_ev.kind = EV_TICK;
            end
            default:
            begin
                q_ev.kind = EV_NONE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: design/cgf_queue.sv
// short event queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module cgf_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire cgf_pkg::event_t push_ev,
    input  wire logic            pop,
    output logic                 full,
    output cgf_pkg::q_entry_t    head
);
    import cgf_pkg::*;

    event_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head.valid = (count_reg != '0);
    assign head.ev    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_ev;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count over depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

FILE: design/cgf_back.sv
// back end: condition latches, phase machine, cooldown timer and result register
`timescale 1ns / 1ps
`default_nettype none
module cgf_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [cgf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cgf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire cgf_pkg::q_entry_t              head,
    output logic                                pop,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                stop_capture,
    output logic                                request_capture,
    output logic                                start_capture,
    output logic [cgf_pkg::PHASE_W-1:0]         phase
);
    import cgf_pkg::*;

    logic [COOL_W-1:0]  cooldown_reg;
    logic [RETRY_W-1:0] retry_limit_reg;

    phase_t             phase_reg;
    phase_t             phase_next;
    rdy_t               rdy_reg;
    rdy_t               rdy_next;
    logic               view_reg;
    logic               view_next;
    logic               perm_reg;
    logic               perm_next;
    logic               frame_reg;
    logic               frame_next;
    logic [RETRY_W-1:0] retries_reg;
    logic [RETRY_W-1:0] retries_next;
    logic               run_reg;
    logic               run_next;
    logic [COOL_W-1:0]  count_reg;
    logic [COOL_W-1:0]  count_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               stop_reg;
    logic               stop_next;
    logic               req_reg;
    logic               req_next;
    logic               start_reg;
    logic               start_next;
    phase_t             out_phase_reg;

    logic               is_cond;
    logic               is_frame;
    logic               is_tick;
    logic               p_off;
    logic               p_hid;
    logic               p_go;
    phase_t             ph1;
    phase_t             ph2;
    logic               enter_cool;
    logic               tick_exp;
    logic               exp_act;
    logic               retry;
    logic               to_final;

    assign pop      = head.valid && (!out_valid_reg || !out_stall);
    assign is_cond  = pop && (head.ev.kind == EV_COND);
    assign is_frame = pop && (head.ev.kind == EV_FRAME);
    assign is_tick  = pop && (head.ev.kind == EV_TICK);

    // latched conditions as seen after this event
    assign rdy_next  = (is_cond && head.ev.cond == CD_READY)  ? head.ev.rdy  : rdy_reg;
    assign view_next = (is_cond && head.ev.cond == CD_VIEW)   ? head.ev.flag : view_reg;
    assign perm_next = (is_cond && head.ev.cond == CD_PERMIT) ? head.ev.flag : perm_reg;

    assign p_off = (rdy_next == RDY_NOT);
    assign p_hid = !p_off && !view_next;
    assign p_go  = !p_off && view_next
                   && !(rdy_next == RDY_FINAL && phase_reg == PH_FINAL);
    assign ph1   = (phase_reg == PH_IDLE) ? PH_REQ : phase_reg;
    assign ph2   = (ph1 == PH_REQ) ? PH_CAP : ph1;
    assign enter_cool = is_cond && p_go && perm_next && rdy_next == RDY_FINAL
                        && ph2 == PH_CAP;

    assign tick_exp = is_tick && run_reg && (count_reg <= COOL_W'(1));
    assign exp_act  = tick_exp && (phase_reg == PH_COOL || phase_reg == PH_FINAL);
    assign retry    = exp_act && !frame_reg && (retries_reg < retry_limit_reg);
    assign to_final = exp_act && !retry;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        priority if (is_cond && p_off)
        begin
            phase_next = PH_IDLE;
        end
        else if (is_cond && p_hid)
        begin
            phase_next = (phase_reg == PH_FINAL) ? PH_FINAL : PH_IDLE;
        end
        else if (is_cond && p_go)
        begin
            if (!perm_next)
            begin
                phase_next = PH_REQ;
            end
            else if (enter_cool)
            begin
                phase_next = PH_COOL;
            end
            else
            begin
                phase_next = ph2;
            end
        end
        else if (to_final)
        begin
            phase_next = PH_FINAL;
        end
    end

    // command pulses and timer side
    always_comb
    begin
        stop_next    = (is_cond && (p_off || p_hid)) || to_final;
        req_next     = is_cond && p_go && phase_reg == PH_IDLE;
        start_next   = is_cond && p_go && perm_next && ph1 == PH_REQ;
        frame_next   = frame_reg;
        retries_next = retries_reg;
        run_next     = run_reg;
        count_next   = count_reg;
        if (enter_cool)
        begin
            frame_next   = 1'b0;
            retries_next = '0;
            run_next     = 1'b1;
            count_next   = cooldown_reg;
        end
        else if (is_cond && p_go && !perm_next)
        begin
            run_next = 1'b0;
        end
        else if (is_frame && phase_reg == PH_COOL)
        begin
            frame_next = 1'b1;
        end
        else if (is_tick && run_reg)
        begin
            if (tick_exp)
            begin
                run_next   = 1'b0;
                count_next = '0;
                if (retry)
                begin
                    retries_next = retries_reg + 1'b1;
                    run_next     = 1'b1;
                    count_next   = cooldown_reg;
                end
            end
            else
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    assign out_valid_next = pop || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cooldown_reg    <= COOL_W'(500);
            retry_limit_reg <= RETRY_W'(2);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_COOLDOWN: cooldown_reg    <= cfg_data[COOL_W-1:0];
                REG_RETRY:    retry_limit_reg <= cfg_data[RETRY_W-1:0];
                default:      cooldown_reg    <= cooldown_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            rdy_reg       <= RDY_NOT;
            view_reg      <= 1'b0;
            perm_reg      <= 1'b0;
            frame_reg     <= 1'b0;
            retries_reg   <= '0;
            run_reg       <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            rdy_reg       <= rdy_next;
            view_reg      <= view_next;
            perm_reg      <= perm_next;
            frame_reg     <= frame_next;
            retries_reg   <= retries_next;
            run_reg       <= run_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            stop_reg      <= stop_next;
            req_reg       <= req_next;
            start_reg     <= start_next;
            out_phase_reg <= phase_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign stop_capture    = stop_reg;
    assign request_capture = req_reg;
    assign start_capture   = start_reg;
    assign phase           = out_phase_reg;

`ifndef SYNTHESIS
    a_start_phase: assert property (@(posedge clk) disable iff (!rst_n)
        pop && start_next |-> (phase_next == PH_CAP || phase_next == PH_COOL))
        else $error("start without capturing phase");

    a_req_phase: assert property (@(posedge clk) disable iff (!rst_n)
        pop && req_next |-> (phase_next != PH_IDLE && phase_next != PH_FINAL))
        else $error("request left phase idle or final");

    a_stop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !(stop_next && (req_next || start_next)))
        else $error("stop together with request or start");
`endif

endmodule
`default_nettype wire

FILE: design/capture_gating_fsm_with_cooldown.sv
// top level of the capture gating controller with cooldown
// a request is held in the event queue, then popped by the back end into its result register
// throughput: one request per cycle while out_stall is low; the back end has a single event path
// a two-entry event queue lets the front keep accepting while the result waits
// reset: asynchronous, active low; phase idle, all conditions cleared, timer stopped
// reset config: cooldown length 500 ticks, retry limit 2
`timescale 1ns / 1ps
`default_nettype none
module capture_gating_fsm_with_cooldown (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [cgf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cgf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [cgf_pkg::CMD_W-1:0]      cmd,
    input  wire logic [cgf_pkg::VALUE_W-1:0]    value,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                stop_capture,
    output logic                                request_capture,
    output logic                                start_capture,
    output logic [cgf_pkg::PHASE_W-1:0]         phase
);
    import cgf_pkg::*;

    logic     q_full;
    logic     q_push;
    event_t   q_ev;
    logic     q_pop;
    q_entry_t q_head;

    cgf_front u_front (
        .cmd      (cmd),
        .value    (value),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_ev     (q_ev)
    );

    cgf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_ev (q_ev),
        .pop     (q_pop),
        .full    (q_full),
        .head    (q_head)
    );

    cgf_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .head            (q_head),
        .pop             (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .stop_capture    (stop_capture),
        .request_capture (request_capture),
        .start_capture   (start_capture),
        .phase           (phase)
    );

endmodule
`default_nettype wire
